>>> sv/circular_orbit_position_unit_assert.svh
// ----------------------------------------------------------------------------
// Orbit position assertion macros
// Concurrent checks on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef CIRCULAR_ORBIT_POSITION_UNIT_ASSERT_SVH
`define CIRCULAR_ORBIT_POSITION_UNIT_ASSERT_SVH

// same-cycle implication
`define COP_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("orbit position check failed");

// next-cycle implication
`define COP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("orbit position check failed");

`endif

>>> sv/cop_pkg.sv
// ----------------------------------------------------------------------------
// Orbit position package
// Fixed-point constants, series divisors, cell payload type and helpers.
// ----------------------------------------------------------------------------
package cop_pkg;

  localparam logic [30:0] Q_ONE       = 31'h4000_0000;   // 1.0 in Q30
  localparam logic [32:0] HALF_PI_Q32 = 33'd6746518852;  // pi/2 * 2^32
  localparam logic [29:0] OCT_SPAN    = 30'h2000_0000;   // one octant, 2^29
  localparam int unsigned NUM_CELLS   = 6;
  localparam logic [25:0] M_PER_KM    = 26'd1000;
  localparam logic signed [29:0] POS_MAX = 30'sd134217727;
  localparam logic signed [29:0] POS_MIN = -30'sd134217728;

  // nested Taylor divisors, innermost first; zero leaves the sine term alone
  localparam int unsigned SIN_DIV [NUM_CELLS] = '{110, 72, 42, 20, 6, 0};
  localparam int unsigned COS_DIV [NUM_CELLS] = '{132, 90, 56, 30, 12, 2};

  typedef struct packed {
    logic [29:0] x2;   // x squared, Q30
    logic [30:0] ts;   // sine nest, Q30
    logic [30:0] tc;   // cosine nest, Q30
    logic [29:0] x;    // folded angle, Q30 radians
    logic [2:0]  oct;  // octant
  } cell_data_t;

  function automatic logic [30:0] mag31(logic signed [31:0] v);
    return v[31] ? 31'(-v) : 31'(v);
  endfunction

  // Q30 product rounding, halves away from zero
  function automatic logic signed [31:0] rnd62(logic [61:0] p, logic neg);
    logic [61:0] s;
    logic [31:0] m;
    s = p + (62'd1 << 29);
    m = s[61:30];
    return neg ? -$signed(m) : $signed(m);
  endfunction

  // round Q30 position product, apply sign, clamp to 28 bits
  function automatic logic [27:0] pos_sat(logic [57:0] p, logic neg);
    logic [57:0] s;
    logic signed [29:0] v;
    s = p + (58'd1 << 29);
    v = $signed({2'b00, s[57:30]});
    if (neg) v = -v;
    if (v > POS_MAX) v = POS_MAX;
    if (v < POS_MIN) v = POS_MIN;
    return v[27:0];
  endfunction

endpackage

>>> sv/circular_orbit_position_unit.sv
// ----------------------------------------------------------------------------
// Circular orbit position unit
// Inertial position in metres of a satellite on a circular orbit, from its
// elements and the time since epoch.
// ----------------------------------------------------------------------------
// Channel  Dir  Bits  Contents
// in_      in   152   radius, inclination, node, anomaly, motion, elapsed
// out_     out   88   pos_x, pos_y, pos_z
//
// One item per cycle while the skid stage is not full.
// The pipe runs through the six three-stage series cells of the trig units.
// Reset clears the valid bits of the pipe, output register and skid stage.
// A held result fills the skid stage; the pipe freezes only while it is full.
// ----------------------------------------------------------------------------
`include "circular_orbit_position_unit_assert.svh"

module circular_orbit_position_unit #(
  parameter int ANGLE_BITS = 24
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // [15:0] radius_km, [39:16] incline_turns, [63:40] node_turns,
  // [87:64] anomaly_turns, [119:88] motion_rate, [151:120] elapsed
  input  logic [151:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // [27:0] pos_x, [55:28] pos_y, [83:56] pos_z, [87:84] zero
  output logic [87:0]  out_tdata
);

  localparam int NS = 29;       // pipe stages before the output register
  localparam int TRIG_END = 23; // stage holding the trig results
  localparam logic [31:0] AMASK = ~(32'hFFFF_FFFF >> ANGLE_BITS);

  logic [NS-1:0] v_r;
  logic          en;
  logic          out_v_r, skid_v_r;
  logic [83:0]   out_r, skid_r, res;

  // input stage
  logic [47:0] mt1_r;
  logic [23:0] inc1_r, node1_r, anom1_r;
  logic [47:0] phase;
  logic [31:0] um2_r, ui2_r, un2_r;
  logic [15:0] rad_r [TRIG_END+1];

  logic signed [31:0] sm, cm, si, ci, sn, cn;

  // combine stages
  logic [61:0] p_cism_r, p_cncm_r, p_sncm_r, p_sism_r;
  logic        n_cism_r, n_cncm_r, n_sncm_r, n_sism_r;
  logic signed [31:0] sn1_r, cn1_r, sn2_r, cn2_r;
  logic [15:0] rad1_r, rad2_r;
  logic signed [31:0] cism2_r, cncm2_r, sncm2_r, cz2_r;
  logic signed [31:0] cncm3_r, sncm3_r, cz3_r;
  logic [61:0] p_t1_r, p_t2_r;
  logic        n_t1_r, n_t2_r;
  logic [25:0] rm3_r, rm4_r;
  logic signed [32:0] cx4_r, cy4_r, cz4_r;
  logic [57:0] p_x5_r, p_y5_r, p_z5_r;
  logic        n_x5_r, n_y5_r, n_z5_r;
  logic signed [32:0] cx_nxt, cy_nxt;
  logic [31:0] mx, my, mz;

  assign en = !skid_v_r;
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[NS-2:0], in_tvalid};
    end
  end

  // epoch anomaly and motion term belong to the same transaction
  assign phase = 48'({anom1_r, 24'd0} + mt1_r);

  always_ff @(posedge clk) begin
    if (en) begin
      mt1_r    <= 48'(64'(in_tdata[119:88]) * 64'(in_tdata[151:120]));
      anom1_r  <= in_tdata[87:64];
      inc1_r   <= in_tdata[39:16];
      node1_r  <= in_tdata[63:40];
      rad_r[0] <= in_tdata[15:0];
      for (int i = 1; i <= TRIG_END; i++) rad_r[i] <= rad_r[i-1];
      um2_r <= phase[47:16] & AMASK;
      ui2_r <= {inc1_r, 8'd0} & AMASK;
      un2_r <= {node1_r, 8'd0} & AMASK;
    end
  end

  cop_trig u_trig_m (.clk(clk), .en(en), .u_in(um2_r), .sin_q(sm), .cos_q(cm));
  cop_trig u_trig_i (.clk(clk), .en(en), .u_in(ui2_r), .sin_q(si), .cos_q(ci));
  cop_trig u_trig_n (.clk(clk), .en(en), .u_in(un2_r), .sin_q(sn), .cos_q(cn));

  always_comb begin
    cx_nxt = 33'(cncm3_r) - 33'(cop_pkg::rnd62(p_t1_r, n_t1_r));
    cy_nxt = 33'(sncm3_r) + 33'(cop_pkg::rnd62(p_t2_r, n_t2_r));
    mx = cx4_r[32] ? 32'(-cx4_r) : 32'(cx4_r);
    my = cy4_r[32] ? 32'(-cy4_r) : 32'(cy4_r);
    mz = cz4_r[32] ? 32'(-cz4_r) : 32'(cz4_r);
    res = {cop_pkg::pos_sat(p_z5_r, n_z5_r),
           cop_pkg::pos_sat(p_y5_r, n_y5_r),
           cop_pkg::pos_sat(p_x5_r, n_x5_r)};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // products of the rotation terms
      p_cism_r <= 62'(cop_pkg::mag31(ci)) * 62'(cop_pkg::mag31(sm));
      p_cncm_r <= 62'(cop_pkg::mag31(cn)) * 62'(cop_pkg::mag31(cm));
      p_sncm_r <= 62'(cop_pkg::mag31(sn)) * 62'(cop_pkg::mag31(cm));
      p_sism_r <= 62'(cop_pkg::mag31(si)) * 62'(cop_pkg::mag31(sm));
      n_cism_r <= ci[31] ^ sm[31];
      n_cncm_r <= cn[31] ^ cm[31];
      n_sncm_r <= sn[31] ^ cm[31];
      n_sism_r <= si[31] ^ sm[31];
      sn1_r    <= sn;
      cn1_r    <= cn;
      rad1_r   <= rad_r[TRIG_END];
      // round
      cism2_r <= cop_pkg::rnd62(p_cism_r, n_cism_r);
      cncm2_r <= cop_pkg::rnd62(p_cncm_r, n_cncm_r);
      sncm2_r <= cop_pkg::rnd62(p_sncm_r, n_sncm_r);
      cz2_r   <= cop_pkg::rnd62(p_sism_r, n_sism_r);
      sn2_r   <= sn1_r;
      cn2_r   <= cn1_r;
      rad2_r  <= rad1_r;
      // node terms on the inclined component
      p_t1_r  <= 62'(cop_pkg::mag31(sn2_r)) * 62'(cop_pkg::mag31(cism2_r));
      p_t2_r  <= 62'(cop_pkg::mag31(cn2_r)) * 62'(cop_pkg::mag31(cism2_r));
      n_t1_r  <= sn2_r[31] ^ cism2_r[31];
      n_t2_r  <= cn2_r[31] ^ cism2_r[31];
      cncm3_r <= cncm2_r;
      sncm3_r <= sncm2_r;
      cz3_r   <= cz2_r;
      rm3_r   <= 26'(rad2_r) * cop_pkg::M_PER_KM;
      // direction cosines
      cx4_r <= cx_nxt;
      cy4_r <= cy_nxt;
      cz4_r <= 33'(cz3_r);
      rm4_r <= rm3_r;
      // scale by radius in metres
      p_x5_r <= 58'(rm4_r) * 58'(mx);
      p_y5_r <= 58'(rm4_r) * 58'(my);
      p_z5_r <= 58'(rm4_r) * 58'(mz);
      n_x5_r <= cx4_r[32];
      n_y5_r <= cy4_r[32];
      n_z5_r <= cz4_r[32];
    end
  end

  // output register with skid stage behind it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (!out_v_r || out_tready) begin
      if (skid_v_r) begin
        out_v_r  <= 1'b1;
        skid_v_r <= 1'b0;
      end else begin
        out_v_r <= v_r[NS-1];
      end
    end else if (v_r[NS-1]) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_v_r || out_tready) begin
      out_r <= skid_v_r ? skid_r : res;
    end else if (en) begin
      skid_r <= res;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {4'd0, out_r};

  `COP_ASSERT_NOW(a_open_when_skid_free, out_tvalid && !out_tready && !skid_v_r, in_tready)
  `COP_ASSERT_NOW(a_skid_behind_output, skid_v_r, out_tvalid)
  `COP_ASSERT_NEXT(a_skid_fills, out_tvalid && !out_tready && v_r[NS-1] && in_tready, !in_tready)

endmodule

>>> sv/cop_cell.sv
// ----------------------------------------------------------------------------
// Orbit position series cell
// One nesting step of the sine and cosine series, t = 1 - (x2*t)/d, sine kept
// if SDIV is 0; three stages: product, reciprocal estimate, correction.
// ----------------------------------------------------------------------------
module cop_cell #(
  parameter int unsigned SDIV = 6,
  parameter int unsigned CDIV = 2
) (
  input  logic               clk,
  input  logic               en,
  input  cop_pkg::cell_data_t d_in,
  output cop_pkg::cell_data_t d_out
);

  localparam logic [31:0] SREC = 32'((64'd1 << 32) / ((SDIV == 0) ? 1 : SDIV));
  localparam logic [31:0] CREC = 32'((64'd1 << 32) / CDIV);

  cop_pkg::cell_data_t da_r, db_r, dc_r;
  logic [59:0] ms_r, mc_r;
  logic [29:0] ps_r, pc_r, qs_r, qc_r;
  logic [29:0] ps_nxt, pc_nxt, qs_nxt, qc_nxt;
  logic [61:0] es, ec;
  logic [37:0] rs, rc;
  logic [29:0] qs_fix, qc_fix;
  cop_pkg::cell_data_t dc_nxt;

  always_comb begin
    ps_nxt = ms_r[59:30];
    pc_nxt = mc_r[59:30];
    es     = 62'(ps_nxt) * 62'(SREC);
    ec     = 62'(pc_nxt) * 62'(CREC);
    qs_nxt = es[61:32];
    qc_nxt = ec[61:32];
  end

  // estimate is low by at most one: fix with one compare
  always_comb begin
    rs     = 38'(ps_r) - 38'(qs_r) * 38'(SDIV);
    rc     = 38'(pc_r) - 38'(qc_r) * 38'(CDIV);
    qs_fix = qs_r + ((rs >= 38'(SDIV)) ? 30'd1 : 30'd0);
    qc_fix = qc_r + ((rc >= 38'(CDIV)) ? 30'd1 : 30'd0);
    dc_nxt = db_r;
    dc_nxt.tc = cop_pkg::Q_ONE - 31'(qc_fix);
    if (SDIV != 0) dc_nxt.ts = cop_pkg::Q_ONE - 31'(qs_fix);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ms_r <= 60'(d_in.x2) * 60'(d_in.ts);
      mc_r <= 60'(d_in.x2) * 60'(d_in.tc);
      da_r <= d_in;
      ps_r <= ps_nxt;
      pc_r <= pc_nxt;
      qs_r <= qs_nxt;
      qc_r <= qc_nxt;
      db_r <= da_r;
      dc_r <= dc_nxt;
    end
  end

  assign d_out = dc_r;

endmodule

>>> sv/cop_trig.sv
// ----------------------------------------------------------------------------
// Orbit position sine/cosine unit
// Octant fold, radian scaling, a row of series cells and octant unfold.
// 22 stages, one angle per cycle while en is high.
// ----------------------------------------------------------------------------
module cop_trig (
  input  logic               clk,
  input  logic               en,
  input  logic [31:0]        u_in,    // angle, full turn = 2^32
  output logic signed [31:0] sin_q,   // Q30
  output logic signed [31:0] cos_q    // Q30
);

  logic [2:0]  oct1_r, oct2_r;
  logic [61:0] prod1_r;
  logic [29:0] x2_r;
  logic [59:0] xx2_r;
  logic [29:0] rem;
  logic [61:0] prod1_nxt, xsum;
  logic [29:0] x_nxt;
  logic [59:0] xxsum;
  cop_pkg::cell_data_t t3_r, t3_nxt;
  cop_pkg::cell_data_t chain [cop_pkg::NUM_CELLS+1];
  logic [60:0] sprod;
  logic [30:0] s0, sv, cv;
  logic signed [31:0] sin_nxt, cos_nxt;
  logic [2:0] oct;

  always_comb begin
    rem = {1'b0, u_in[28:0]};
    if (u_in[29]) rem = cop_pkg::OCT_SPAN - rem;
    prod1_nxt = 62'(64'(rem) * 64'(cop_pkg::HALF_PI_Q32));
    xsum  = prod1_r + (62'd1 << 31);
    x_nxt = xsum[61:32];
    xxsum = xx2_r + (60'd1 << 29);
    t3_nxt.x2  = xxsum[59:30];
    t3_nxt.ts  = cop_pkg::Q_ONE;
    t3_nxt.tc  = cop_pkg::Q_ONE;
    t3_nxt.x   = x2_r;
    t3_nxt.oct = oct2_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      oct1_r  <= u_in[31:29];
      prod1_r <= prod1_nxt;
      oct2_r  <= oct1_r;
      x2_r    <= x_nxt;
      xx2_r   <= 60'(x_nxt) * 60'(x_nxt);
      t3_r    <= t3_nxt;
    end
  end

  assign chain[0] = t3_r;

  for (genvar i = 0; i < cop_pkg::NUM_CELLS; i++) begin : g_cell
    cop_cell #(
      .SDIV(cop_pkg::SIN_DIV[i]),
      .CDIV(cop_pkg::COS_DIV[i])
    ) u_cell (
      .clk  (clk),
      .en   (en),
      .d_in (chain[i]),
      .d_out(chain[i+1])
    );
  end

  // unfold: swap sine and cosine in octants 1, 2, 5, 6, then apply signs
  always_comb begin
    oct   = chain[cop_pkg::NUM_CELLS].oct;
    sprod = 61'(chain[cop_pkg::NUM_CELLS].x) * 61'(chain[cop_pkg::NUM_CELLS].ts);
    s0    = {1'b0, sprod[59:30]};
    if (oct inside {3'd1, 3'd2, 3'd5, 3'd6}) begin
      sv = chain[cop_pkg::NUM_CELLS].tc;
      cv = s0;
    end else begin
      sv = s0;
      cv = chain[cop_pkg::NUM_CELLS].tc;
    end
    sin_nxt = oct[2] ? -$signed({1'b0, sv}) : $signed({1'b0, sv});
    cos_nxt = (oct inside {[3'd2:3'd5]}) ? -$signed({1'b0, cv}) : $signed({1'b0, cv});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sin_q <= sin_nxt;
      cos_q <= cos_nxt;
    end
  end

endmodule
